@@ hdl/sda_pkg.sv @@
// ----------------------------------------------------------------------------
// sda_pkg: shared types and constants of the angle smoothing block
// Fixed-point constants, serial divider sizing and the divider request type.
// ----------------------------------------------------------------------------
package sda_pkg;

  // configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 1'd1;

  localparam logic [15:0] SMOOTH_TIME_RST = 16'd6554;
  localparam logic [15:0] MAX_SPEED_RST   = 16'hffff;

  // fixed-point constants
  localparam logic [15:0]        ST_FLOOR    = 16'd7;
  localparam logic signed [17:0] PI_Q12      = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
  localparam logic [15:0]        C048_Q16    = 16'd31457;
  localparam logic [15:0]        C0235_Q16   = 16'd15401;
  localparam logic [24:0]        X_LIMIT_Q16 = 25'h100_0000;
  localparam logic [37:0]        DEN_ONE     = 38'd65536;

  // serial divider sizing
  localparam int unsigned DIV_NUM_W = 49;
  localparam int unsigned DIV_DEN_W = 38;
  localparam int unsigned DIV_CNT_W = 6;

  // left-aligned dividends and step counts of the three divisions
  localparam logic [DIV_NUM_W-1:0] ONE_Q48       = {1'b1, {(DIV_NUM_W-1){1'b0}}};
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_OMEGA = 6'd34;
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_X     = 6'd33;
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_DECAY = 6'd49;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] count;
  } sda_div_req_t;

endpackage

@@ hdl/sda_div.sv @@
// ----------------------------------------------------------------------------
// sda_div: serial restoring divider
// One quotient bit per cycle over a left-aligned dividend, count steps long.
// ----------------------------------------------------------------------------
module sda_div
  import sda_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sda_div_req_t         req_i,
  input  logic [DIV_NUM_W-1:0] dividend_i,
  input  logic [DIV_DEN_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_NUM_W-1:0] quo_q;

  logic [DIV_DEN_W:0] trial;
  logic [DIV_DEN_W:0] diff;
  logic               fits;

  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.count;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= divisor_i;
      rem_q <= '0;
      num_q <= dividend_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a running division");

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("divider busy with an empty step count");
`endif

endmodule

@@ hdl/smooth_damp_angle_top.sv @@
// ----------------------------------------------------------------------------
// smooth_damp_angle_top: critically damped angle smoothing
// Moves an angle toward a target with a spring and keeps the velocity.
// ----------------------------------------------------------------------------
// Input channel: current_angle, target_angle (Q3.12 rad) and delta_time
// (Q0.16 s); a transaction moves when in_valid_i is high and in_stall_o low.
// Output channel: new_angle (Q3.12), new_velocity (Q15.16) and snapped;
// the receiver holds out_stall_i high to keep a result waiting.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 smooth_time, 1 max_speed) in the same cycle; write only while idle.
// The sequencer takes a new transaction only in its idle state, once the
// previous result has entered the output register. The serial divider
// forms one quotient bit per cycle: 34 steps for 2/smooth_time, 33 for
// 2*dt/smooth_time and 49 for the decay factor, and the shared 33x33
// multiplier forms the polynomial and the spring update.
// The output register frees the sequencer: a result may wait while the next
// input is taken; a second result waits in the last step until it drains.
// Reset clears the velocity to zero and loads the register reset values.
// ----------------------------------------------------------------------------
module smooth_damp_angle_top
  import sda_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [15:0]   current_angle_i,
  input  logic signed [15:0]   target_angle_i,
  input  logic [15:0]          delta_time_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   new_angle_o,
  output logic signed [31:0]   new_velocity_o,
  output logic                 snapped_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP, S_OMEGA, S_CHANGE, S_OC, S_S, S_SDT, S_TEMP, S_OT, S_NVA,
    S_XWAIT, S_X2, S_X3, S_X3I, S_C1, S_C2, S_C3, S_C4, S_DEC, S_DECWAIT,
    S_NV1, S_NV2, S_NV3, S_R1, S_R2, S_FIN
  } state_e;

  state_e state_q;

  // configuration and kept state
  logic [15:0]        st_q;
  logic [15:0]        ms_q;
  logic signed [31:0] v_q;

  // output register
  logic               out_valid_q;
  logic signed [15:0] new_angle_q;
  logic signed [31:0] new_vel_q;
  logic               snapped_q;

  // datapath registers
  logic signed [15:0] cur_q;
  logic [15:0]        dt_q;
  logic signed [17:0] r_q;
  logic               odd_q;
  logic [30:0]        omega_q;
  logic [19:0]        maxc_q;
  logic signed [15:0] change_q;
  logic signed [17:0] clamped_q;
  logic signed [34:0] s_q;
  logic signed [33:0] temp_q;
  logic signed [48:0] a_q;
  logic [24:0]        x_q;
  logic [32:0]        x2_q;
  logic [40:0]        x3_q;
  logic [37:0]        den_q;
  logic [32:0]        decay_q;
  logic [63:0]        acc_q;
  logic signed [48:0] nv_q;
  logic signed [45:0] res_q;
  logic [65:0]        prod_q;

  // shared multiplier
  logic [32:0] mul_a;
  logic [32:0] mul_b;
  logic [65:0] prod_d;

  // divider
  sda_div_req_t         div_req;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  // helpers
  logic               in_fire;
  logic               fin_go;
  logic [15:0]        st_eff;
  logic               wrap_gt;
  logic               wrap_lt;
  logic [15:0]        chg_abs;
  logic [34:0]        s_abs;
  logic [33:0]        temp_abs;
  logic [48:0]        a_abs;
  logic signed [34:0] a2;
  logic [34:0]        a2_abs;
  logic signed [20:0] neg_r;
  logic signed [20:0] maxc_s;
  logic signed [20:0] chg_full;
  logic signed [34:0] term_s;
  logic signed [33:0] temp_s;
  logic [63:0]        w64;
  logic [63:0]        wn64;
  logic signed [48:0] sh_s;
  logic [63:0]        dsum;
  logic [47:0]        dmag;
  logic signed [48:0] nv_s;
  logic [43:0]        rq;
  logic signed [45:0] rq_s;
  logic signed [17:0] wrapped;
  logic               snap;
  logic [15:0]        ang_fin;
  logic [31:0]        vel_fin;

  function automatic logic [15:0] sat_angle(input logic signed [45:0] v);
    if (v > 46'sd32767) begin
      sat_angle = 16'h7fff;
    end else if (v < -46'sd32768) begin
      sat_angle = 16'h8000;
    end else begin
      sat_angle = v[15:0];
    end
  endfunction

  function automatic logic [31:0] sat_vel(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      sat_vel = 32'h7fff_ffff;
    end else if (v < -49'sd2147483648) begin
      sat_vel = 32'h8000_0000;
    end else begin
      sat_vel = v[31:0];
    end
  endfunction

  assign in_fire = in_valid_i && !in_stall_o;
  assign fin_go  = !out_valid_q || !out_stall_i;
  assign st_eff  = (st_q < ST_FLOOR) ? ST_FLOOR : st_q;
  assign wrap_gt = (r_q > PI_Q12);
  assign wrap_lt = (r_q < -PI_Q12);

  // magnitudes for the unsigned multiplier
  assign chg_abs  = change_q[15] ? 16'(-change_q) : 16'(change_q);
  assign s_abs    = s_q[34] ? 35'(-s_q) : 35'(s_q);
  assign temp_abs = temp_q[33] ? 34'(-temp_q) : 34'(temp_q);
  assign a_abs    = a_q[48] ? 49'(-a_q) : 49'(a_q);
  assign a2       = (35'(change_q) <<< 4) + 35'(temp_q);
  assign a2_abs   = a2[34] ? 35'(-a2) : 35'(a2);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_WRAP, S_OMEGA: begin
        mul_a = 33'(ms_q);
        mul_b = 33'(st_eff);
      end
      S_OC: begin
        mul_a = 33'(omega_q);
        mul_b = 33'(chg_abs);
      end
      S_SDT: begin
        mul_a = s_abs[32:0];
        mul_b = 33'(dt_q);
      end
      S_OT: begin
        mul_a = 33'(omega_q);
        mul_b = temp_abs[32:0];
      end
      S_X2: begin
        mul_a = 33'(x_q);
        mul_b = 33'(x_q);
      end
      S_X3I: begin
        mul_a = x2_q;
        mul_b = 33'(x_q);
      end
      S_C1: begin
        mul_a = 33'(C048_Q16);
        mul_b = x2_q;
      end
      S_C2: begin
        mul_a = 33'(C0235_Q16);
        mul_b = 33'(x3_q[40:16]);
      end
      S_C3: begin
        mul_a = 33'(C0235_Q16);
        mul_b = 33'(x3_q[15:0]);
      end
      S_NV1: begin
        mul_a = a_abs[48:16];
        mul_b = decay_q;
      end
      S_NV2: begin
        mul_a = 33'(a_abs[15:0]);
        mul_b = decay_q;
      end
      S_NV3: begin
        mul_a = 33'(a2_abs[34:16]);
        mul_b = decay_q;
      end
      S_R1: begin
        mul_a = 33'(a2_abs[15:0]);
        mul_b = decay_q;
      end
      default: ;
    endcase
  end

  assign prod_d = 66'(mul_a) * 66'(mul_b);

  // divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.count = DIV_CNT_OMEGA;
    div_num       = ONE_Q48;
    div_den       = DIV_DEN_W'(st_eff);
    case (state_q)
      S_IDLE: begin
        div_req.start = in_fire;
      end
      S_OMEGA: begin
        div_req.start = div_done;
        div_req.count = DIV_CNT_X;
        div_num       = {dt_q, 33'b0};
      end
      S_DEC: begin
        div_req.start = 1'b1;
        div_req.count = DIV_CNT_DECAY;
        div_den       = den_q;
      end
      default: ;
    endcase
  end

  sda_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // product post-processing
  always_comb begin
    neg_r    = -21'(r_q);
    maxc_s   = $signed({1'b0, maxc_q});
    if (neg_r > maxc_s) begin
      chg_full = maxc_s;
    end else if (neg_r < -maxc_s) begin
      chg_full = -maxc_s;
    end else begin
      chg_full = neg_r;
    end

    term_s = change_q[15] ? -$signed({2'b0, prod_q[44:12]})
                          : $signed({2'b0, prod_q[44:12]});
    temp_s = s_q[34] ? -$signed({1'b0, prod_q[48:16]})
                     : $signed({1'b0, prod_q[48:16]});

    // omega * temp kept modulo 2^64 before the shift toward zero
    w64  = temp_q[33] ? (~prod_q[63:0] + 64'd1) : prod_q[63:0];
    wn64 = ~w64 + 64'd1;
    if (w64[63]) begin
      sh_s = -$signed({1'b0, wn64[63:16]});
    end else begin
      sh_s = $signed({1'b0, w64[63:16]});
    end

    // second half of the decay product
    dsum = acc_q + 64'(prod_q[48:16]);
    dmag = dsum[63:16];
    nv_s = a_q[48] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    rq   = dmag[47:4];
    rq_s = a2[34] ? -$signed({2'b0, rq}) : $signed({2'b0, rq});

    wrapped = 18'(cur_q) + r_q;
    snap    = ((r_q > 18'sd0) == (res_q > 46'(wrapped)));
    ang_fin = sat_angle(snap ? 46'(wrapped) : res_q);
    vel_fin = snap ? 32'd0 : sat_vel(nv_q);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cur_q <= current_angle_i;
          dt_q  <= delta_time_i;
          r_q   <= 18'(target_angle_i) - 18'(current_angle_i);
          odd_q <= 1'b0;
        end
      end
      S_WRAP: begin
        if (wrap_gt) begin
          r_q   <= r_q - TWO_PI_Q12;
          odd_q <= ~odd_q;
        end else if (wrap_lt) begin
          r_q   <= r_q + TWO_PI_Q12;
          odd_q <= ~odd_q;
        end else if (odd_q) begin
          // tie at +-pi goes the way that keeps the turn count even
          if (r_q == PI_Q12) begin
            r_q <= r_q - TWO_PI_Q12;
          end else if (r_q == -PI_Q12) begin
            r_q <= r_q + TWO_PI_Q12;
          end
        end
      end
      S_OMEGA: begin
        if (div_done) begin
          omega_q <= div_quo[30:0];
          maxc_q  <= prod_q[31:12];
        end
      end
      S_CHANGE: begin
        change_q  <= 16'(chg_full);
        clamped_q <= 18'(cur_q) - 18'(16'(chg_full));
      end
      S_S:    s_q    <= 35'(v_q) + term_s;
      S_TEMP: temp_q <= temp_s;
      S_NVA:  a_q    <= 49'(v_q) - sh_s;
      S_XWAIT: begin
        if (div_done) begin
          x_q <= (div_quo > DIV_NUM_W'(X_LIMIT_Q16)) ? X_LIMIT_Q16 : div_quo[24:0];
        end
      end
      S_X3:  x2_q  <= prod_q[48:16];
      S_C1:  x3_q  <= prod_q[56:16];
      S_C2:  den_q <= DEN_ONE + 38'(x_q) + 38'(prod_q[47:16]);
      S_C3:  den_q <= den_q + prod_q[37:0];
      S_C4:  den_q <= den_q + 38'(prod_q[29:16]);
      S_DECWAIT: begin
        if (div_done) begin
          decay_q <= div_quo[32:0];
        end
      end
      S_NV2: acc_q <= prod_q[63:0];
      S_NV3: nv_q  <= nv_s;
      S_R1:  acc_q <= prod_q[63:0];
      S_R2:  res_q <= 46'(clamped_q) + rq_s;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= SMOOTH_TIME_RST;
      ms_q        <= MAX_SPEED_RST;
      v_q         <= '0;
      out_valid_q <= 1'b0;
      new_angle_q <= '0;
      new_vel_q   <= '0;
      snapped_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SMOOTH_TIME: st_q <= cfg_wdata_i;
          REG_MAX_SPEED:   ms_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE:   if (in_fire) state_q <= S_WRAP;
        S_WRAP:   if (!wrap_gt && !wrap_lt) state_q <= S_OMEGA;
        S_OMEGA:  if (div_done) state_q <= S_CHANGE;
        S_CHANGE: state_q <= S_OC;
        S_OC:     state_q <= S_S;
        S_S:      state_q <= S_SDT;
        S_SDT:    state_q <= S_TEMP;
        S_TEMP:   state_q <= S_OT;
        S_OT:     state_q <= S_NVA;
        S_NVA:    state_q <= S_XWAIT;
        S_XWAIT:  if (div_done) state_q <= S_X2;
        S_X2:     state_q <= S_X3;
        S_X3:     state_q <= S_X3I;
        S_X3I:    state_q <= S_C1;
        S_C1:     state_q <= S_C2;
        S_C2:     state_q <= S_C3;
        S_C3:     state_q <= S_C4;
        S_C4:     state_q <= S_DEC;
        S_DEC:    state_q <= S_DECWAIT;
        S_DECWAIT: if (div_done) state_q <= S_NV1;
        S_NV1:    state_q <= S_NV2;
        S_NV2:    state_q <= S_NV3;
        S_NV3:    state_q <= S_R1;
        S_R1:     state_q <= S_R2;
        S_R2:     state_q <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            new_angle_q <= ang_fin;
            new_vel_q   <= vel_fin;
            snapped_q   <= snap;
            out_valid_q <= 1'b1;
            v_q         <= vel_fin;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign new_angle_o    = new_angle_q;
  assign new_velocity_o = new_vel_q;
  assign snapped_o      = snapped_q;

`ifndef ASSERT_OFF
  a_snap_clears_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && snapped_o) |-> (new_velocity_o == 32'sd0))
    else $error("snapped result carries a nonzero velocity");

  a_vel_tracks_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && fin_go) |=> (v_q == new_velocity_o))
    else $error("kept velocity differs from the delivered one");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && out_stall_i) |=> (state_q == S_FIN))
    else $error("result overwrote a pending transaction");
`endif

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the angle smoothing block
// Drives angle and time transactions with random gaps on both channels,
// predicts every result with a fixed-point spring model kept in the bench
// and checks angle, velocity and snap flag in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
  import sda_pkg::*;

  localparam int  HALF_PERIOD = 2;
  localparam int  RESET_CYCLES = 12;
  localparam int  TAIL_CYCLES = 150;
  localparam longint TIMEOUT = 64'd8_000_000;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [31:0] velocity;
    logic               snap;
  } damp_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [15:0]   cur_angle = '0;
  logic signed [15:0]   tgt_angle = '0;
  logic [15:0]          dt_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [15:0]   new_angle;
  logic signed [31:0]   new_velocity;
  logic                 snapped;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_SMOOTH_TIME;
  logic [15:0]          cfg_wdata = '0;

  // bench copy of the block state and registers
  logic [15:0]        model_smooth_time = SMOOTH_TIME_RST;
  logic [15:0]        model_max_speed = MAX_SPEED_RST;
  logic signed [31:0] model_velocity = '0;
  logic signed [15:0] last_angle = '0;

  damp_result_t pending_results[$];
  int           error_count = 0;
  bit           gaps_on = 1'b1;
  int           stall_hold = 0;

  smooth_damp_angle_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .current_angle_i (cur_angle),
    .target_angle_i  (tgt_angle),
    .delta_time_i    (dt_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .new_angle_o     (new_angle),
    .new_velocity_o  (new_velocity),
    .snapped_o       (snapped),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic longint shift_tz(longint v, int n);
    if (v < 0) return -((-v) >> n);
    return v >> n;
  endfunction

  // a * d / 2^32 with truncation toward zero
  function automatic longint scale_decay(longint a, longint unsigned d);
    longint unsigned m;
    longint unsigned p;
    m = (a < 0) ? -a : a;
    p = ((m >> 16) * d + (((m & 64'hffff) * d) >> 16)) >> 16;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic damp_result_t predict_damp(input logic signed [15:0] cur,
                                                input logic signed [15:0] tgt,
                                                input logic [15:0] dt,
                                                input logic signed [31:0] vel);
    damp_result_t    res_item;
    longint          c, t, r, wrapped, omega, maxc, change, clamped;
    longint          s, tmp, nv, res, vl, dtl;
    longint unsigned st, x, x2, x3, den, decay;
    int              turns;
    logic            snap;
    c = cur;
    t = tgt;
    vl = vel;
    dtl = dt;
    st = (model_smooth_time < ST_FLOOR) ? ST_FLOOR : model_smooth_time;
    r = t - c;
    turns = 0;
    while (r > PI_Q12) begin
      r -= TWO_PI_Q12;
      turns++;
    end
    while (r < -PI_Q12) begin
      r += TWO_PI_Q12;
      turns--;
    end
    // a tie at +-pi goes the way that removes an even count of turns
    if ((turns & 1) != 0) begin
      if (r == PI_Q12) r -= TWO_PI_Q12;
      else if (r == -PI_Q12) r += TWO_PI_Q12;
    end
    wrapped = c + r;

    omega = (64'd1 << 33) / st;
    x = dt;
    x = (x << 17) / st;
    if (x > X_LIMIT_Q16) x = X_LIMIT_Q16;
    x2 = (x * x) >> 16;
    x3 = (x2 * x) >> 16;
    den = DEN_ONE + x + ((C048_Q16 * x2) >> 16) + ((C0235_Q16 * x3) >> 16);
    decay = (64'd1 << 48) / den;

    maxc = (st * model_max_speed) >> 12;
    change = clip(-r, -maxc, maxc);
    clamped = c - change;

    s = vl + shift_tz(omega * change, 12);
    tmp = shift_tz(s * dtl, 16);
    nv = scale_decay(vl - shift_tz(omega * tmp, 16), decay);
    res = clamped + shift_tz(scale_decay(change * 16 + tmp, decay), 4);

    snap = ((r > 0) == (res > wrapped));
    if (snap) begin
      res = wrapped;
      nv = 0;
    end
    nv = clip(nv, -64'sd2147483648, 64'sd2147483647);
    res = clip(res, -32768, 32767);
    res_item.angle = res[15:0];
    res_item.velocity = nv[31:0];
    res_item.snap = snap;
    return res_item;
  endfunction

  task automatic send_item(input logic signed [15:0] cur, input logic signed [15:0] tgt,
                           input logic [15:0] dt);
    damp_result_t want;
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(5, 180) : $urandom_range(1, 4))
        @(negedge clk);
    end
    in_valid <= 1'b1;
    cur_angle <= cur;
    tgt_angle <= tgt;
    dt_in <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_damp(cur, tgt, dt, model_velocity);
    model_velocity = want.velocity;
    last_angle = want.angle;
    pending_results.push_back(want);
  endtask

  // idle the input and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    if (idx == REG_SMOOTH_TIME) model_smooth_time = value;
    else model_max_speed = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] st, input logic [15:0] ms);
    settle();
    write_reg(REG_SMOOTH_TIME, st);
    write_reg(REG_MAX_SPEED, ms);
  endtask

  // reset settings: wrap ties, zero difference, field extremes, saturation
  task automatic test_wrap_and_limits();
    send_item(16'sd0, 16'sd0, 16'd1092);
    send_item(16'sd0, 16'sd12868, 16'd1092);
    send_item(16'sd0, -16'sd12868, 16'd1092);
    send_item(-16'sd19302, 16'sd19302, 16'd1092);
    send_item(16'sd19302, -16'sd19302, 16'd1092);
    send_item(-16'sd32170, 16'sd32170, 16'd1092);
    send_item(-16'sd32768, 16'sd32767, 16'd0);
    send_item(16'sd32767, -16'sd32768, 16'd65535);
    send_item(16'sd1000, -16'sd1000, 16'd65535);
  endtask

  // smooth time below the floor and at it, decay factor saturated
  task automatic test_small_smooth_time();
    apply_setting(16'd0, 16'hffff);
    send_item(16'sd0, 16'sd20000, 16'd65535);
    send_item(16'sd20000, -16'sd20000, 16'd1);
    send_item(-16'sd5000, 16'sd5000, 16'd65535);
    apply_setting(ST_FLOOR, 16'd1);
    send_item(16'sd0, 16'sd32767, 16'd65535);
    send_item(16'sd32767, 16'sd0, 16'd100);
  endtask

  // zero and full speed limit with the slowest spring
  task automatic test_speed_limit();
    apply_setting(16'hffff, 16'd0);
    send_item(-16'sd32768, 16'sd30000, 16'd65535);
    send_item(16'sd100, -16'sd100, 16'd30000);
    apply_setting(16'hffff, 16'hffff);
    send_item(-16'sd30000, 16'sd30000, 16'd65535);
    send_item(16'sd30000, -16'sd30000, 16'd4000);
    send_item(16'sd12345, -16'sd20000, 16'd65535);
  endtask

  // closed-loop tracking runs: the angle fed back is the last smoothed angle
  task automatic run_tracking(input int count, input int pause_at);
    int                 left;
    int                 k;
    logic signed [15:0] goal;
    logic signed [15:0] pos;
    logic [15:0]        dt;
    left = 0;
    goal = '0;
    for (k = 0; k < count; k++) begin
      if (k == pause_at) settle();
      if (left == 0) begin
        left = $urandom_range(4, 30);
        goal = $urandom;
        pos = $urandom;
      end else if ($urandom_range(9) == 0) begin
        pos = $urandom;
      end else begin
        pos = last_angle;
      end
      if ($urandom_range(7) == 0) goal = $urandom;
      else if ($urandom_range(3) == 0) goal = goal + 16'($urandom_range(2000)) - 16'd1000;
      dt = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(300, 3000));
      send_item(pos, goal, dt);
      left--;
    end
  endtask

  task automatic test_tracking();
    apply_setting(SMOOTH_TIME_RST, MAX_SPEED_RST);
    run_tracking(90, -1);
    apply_setting(16'($urandom_range(7, 3000)), 16'($urandom));
    run_tracking(90, 45);
    // one long stretch with both channels always ready
    gaps_on = 1'b0;
    apply_setting(16'hffff, 16'hffff);
    run_tracking(90, -1);
    gaps_on = 1'b1;
    apply_setting(16'($urandom), 16'($urandom_range(2000)));
    run_tracking(90, -1);
    apply_setting(16'd0, 16'hffff);
    run_tracking(90, -1);
  endtask

  task automatic test_noise();
    repeat (4) begin
      apply_setting(16'($urandom), 16'($urandom));
      repeat (50) send_item(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // receiver stalls: mostly short bursts, now and then one long enough
  // that a second result backs up behind the first
  always @(negedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else if (gaps_on && $urandom_range(99) < 4) begin
      out_stall <= 1'b1;
      stall_hold = ($urandom_range(39) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    damp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: angle %0d velocity %0d",
               new_angle, new_velocity);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (new_angle !== want.angle) begin
          $error("new_angle mismatch: expected %0d, got %0d", want.angle, new_angle);
          error_count++;
        end
        if (new_velocity !== want.velocity) begin
          $error("new_velocity mismatch: expected %0d, got %0d", want.velocity, new_velocity);
          error_count++;
        end
        if (snapped !== want.snap) begin
          $error("snapped mismatch: expected %0d, got %0d", want.snap, snapped);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_wrap_and_limits();
    test_small_smooth_time();
    test_speed_limit();
    test_tracking();
    test_noise();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("simulation failed");
    $finish;
  end

endmodule
